// ===== hw/rtl/ctpt_pkg.sv =====
// Shared types and constants for the client-to-parent table with aging.
// No dependencies; imported by the table core.
package ctpt_pkg;

  localparam int TABLE_SLOTS = 16;
  localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);

  localparam logic [7:0] DEFAULT_TIMEOUT = 8'd3;

  localparam logic [1:0] OP_REPORT = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [2:0] ST_UPDATED  = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_DROPPED  = 3'd2;
  localparam logic [2:0] ST_TICKED   = 3'd3;
  localparam logic [2:0] ST_READ     = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RPT,
    S_TICK,
    S_RD,
    S_RDW,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [63:0] client_high;
    logic [63:0] client_low;
    logic [63:0] parent_high;
    logic [63:0] parent_low;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] slot;
    logic       entry_valid;
    entry_t     entry;
    logic [4:0] removed_count;
  } res_t;

endpackage

// ===== hw/rtl/client_parent_table_with_aging_core.sv =====
// Client-to-parent table with aging: entry memory, valid bits and scan control.
// Depends on ctpt_pkg for sizes, codes, entry and result types.
// Report and tick scan the single-port entry memory, one slot per cycle; a report
// stops early on a match. A read does one memory read with registered data.
// Input stalls until the result reaches the output register, so a new word is not
// taken while one is in flight; a waiting result does not block the next word.
// Reset clears the valid bits, the time counter and out_valid, and loads a timeout of 3;
// entry memory is not cleared, stale entries stay hidden by valid.
module client_parent_table_with_aging_core
  import ctpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [63:0] in_client_addr_high,
  input  logic [63:0] in_client_addr_low,
  input  logic [63:0] in_parent_addr_high,
  input  logic [63:0] in_parent_addr_low,
  input  logic [3:0]  in_read_slot,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [3:0]  out_slot,
  output logic        out_entry_valid,
  output logic [63:0] out_entry_client_high,
  output logic [63:0] out_entry_client_low,
  output logic [63:0] out_entry_parent_high,
  output logic [63:0] out_entry_parent_low,
  output logic [31:0] out_entry_stamp,
  output logic [4:0]  out_removed_count
);

  entry_t mem [TABLE_SLOTS];
  entry_t rd_data_r;
  entry_t wr_data;
  logic              mem_we;
  logic [SLOT_W-1:0] wr_addr;
  logic [SLOT_W-1:0] rd_addr;

  state_t state_r, state_nxt;

  logic [TABLE_SLOTS-1:0] valid_r, valid_nxt;
  logic [31:0]            now_r, now_nxt;
  logic [7:0]             timeout_r;

  logic [1:0]  op_r;
  logic [63:0] client_high_r, client_low_r, parent_high_r, parent_low_r;
  logic [3:0]  rslot_r;

  logic [CNT_W-1:0]  iss_r, iss_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic [SLOT_W-1:0] chk_idx_r, chk_idx_nxt;
  logic              free_fnd_r, free_fnd_nxt;
  logic [SLOT_W-1:0] free_idx_r, free_idx_nxt;
  logic [CNT_W-1:0]  freed_r, freed_nxt;

  res_t res_r, res_nxt;
  res_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;

  logic accept;
  logic issuing;
  logic last_chk;
  logic hit;
  logic expired;
  logic done;
  logic [31:0] age;
  logic rd_in_range;
  logic [SLOT_W-1:0] rd_idx;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  assign issuing  = ((state_r == S_RPT) || (state_r == S_TICK)) &&
                    (iss_r != CNT_W'(TABLE_SLOTS));
  assign last_chk = (chk_idx_r == SLOT_W'(TABLE_SLOTS - 1));
  assign hit      = valid_r[chk_idx_r] &&
                    (rd_data_r.client_high == client_high_r) &&
                    (rd_data_r.client_low == client_low_r);
  assign age      = now_r - rd_data_r.stamp;
  assign expired  = valid_r[chk_idx_r] && (age >= {24'd0, timeout_r});

  assign rd_in_range = (32'(rslot_r) < 32'(TABLE_SLOTS));
  assign rd_idx      = SLOT_W'(rslot_r);
  assign rd_addr     = (state_r == S_RD) ? rd_idx : iss_r[SLOT_W-1:0];

  assign done = ((state_r == S_RPT) && chk_vld_r && (hit || last_chk)) ||
                ((state_r == S_TICK) && chk_vld_r && last_chk) ||
                (state_r == S_RDW);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_REPORT: state_nxt = S_RPT;
            OP_TICK:   state_nxt = S_TICK;
            default:   state_nxt = S_RD;
          endcase
        end
      end
      S_RPT:   if (done) state_nxt = S_OUT;
      S_TICK:  if (done) state_nxt = S_OUT;
      S_RD:    state_nxt = S_RDW;
      S_RDW:   state_nxt = S_OUT;
      S_OUT:   if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    valid_nxt     = valid_r;
    now_nxt       = now_r;
    iss_nxt       = iss_r;
    chk_vld_nxt   = issuing;
    chk_idx_nxt   = iss_r[SLOT_W-1:0];
    free_fnd_nxt  = free_fnd_r;
    free_idx_nxt  = free_idx_r;
    freed_nxt     = freed_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    mem_we        = 1'b0;
    wr_addr       = chk_idx_r;
    wr_data       = '{client_high: client_high_r, client_low: client_low_r,
                      parent_high: parent_high_r, parent_low: parent_low_r,
                      stamp: now_r};

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (issuing) begin
      iss_nxt = iss_r + CNT_W'(1);
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          iss_nxt      = '0;
          chk_vld_nxt  = 1'b0;
          free_fnd_nxt = 1'b0;
          free_idx_nxt = '0;
          freed_nxt    = '0;
          if (in_op == OP_TICK) begin
            now_nxt = now_r + 32'd1;
          end
        end
      end
      S_RPT: begin
        if (chk_vld_r) begin
          res_nxt = '0;
          if (hit) begin
            mem_we         = 1'b1;
            res_nxt.status = ST_UPDATED;
            res_nxt.slot   = 4'(chk_idx_r);
          end else begin
            if (!free_fnd_r && !valid_r[chk_idx_r]) begin
              free_fnd_nxt = 1'b1;
              free_idx_nxt = chk_idx_r;
            end
            if (last_chk) begin
              if (free_fnd_nxt) begin
                mem_we                  = 1'b1;
                wr_addr                 = free_idx_nxt;
                valid_nxt[free_idx_nxt] = 1'b1;
                res_nxt.status          = ST_INSERTED;
                res_nxt.slot            = 4'(free_idx_nxt);
              end else begin
                res_nxt.status = ST_DROPPED;
              end
            end
          end
        end
      end
      S_TICK: begin
        if (chk_vld_r) begin
          if (expired) begin
            valid_nxt[chk_idx_r] = 1'b0;
            freed_nxt            = freed_r + CNT_W'(1);
          end
          if (last_chk) begin
            res_nxt               = '0;
            res_nxt.status        = ST_TICKED;
            res_nxt.removed_count = 5'(freed_nxt);
          end
        end
      end
      S_RDW: begin
        res_nxt        = '0;
        res_nxt.status = ST_READ;
        res_nxt.slot   = rslot_r;
        if (rd_in_range && valid_r[rd_idx]) begin
          res_nxt.entry_valid = 1'b1;
          res_nxt.entry       = rd_data_r;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      now_r       <= '0;
      timeout_r   <= DEFAULT_TIMEOUT;
      out_valid_r <= 1'b0;
      iss_r       <= '0;
      chk_vld_r   <= 1'b0;
      free_fnd_r  <= 1'b0;
      freed_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      now_r       <= now_nxt;
      out_valid_r <= out_valid_nxt;
      iss_r       <= iss_nxt;
      chk_vld_r   <= chk_vld_nxt;
      free_fnd_r  <= free_fnd_nxt;
      freed_r     <= freed_nxt;
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r          <= in_op;
      client_high_r <= in_client_addr_high;
      client_low_r  <= in_client_addr_low;
      parent_high_r <= in_parent_addr_high;
      parent_low_r  <= in_parent_addr_low;
      rslot_r       <= in_read_slot;
    end
    chk_idx_r  <= chk_idx_nxt;
    free_idx_r <= free_idx_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_r.status;
  assign out_slot              = out_r.slot;
  assign out_entry_valid       = out_r.entry_valid;
  assign out_entry_client_high = out_r.entry.client_high;
  assign out_entry_client_low  = out_r.entry.client_low;
  assign out_entry_parent_high = out_r.entry.parent_high;
  assign out_entry_parent_low  = out_r.entry.parent_low;
  assign out_entry_stamp       = out_r.entry.stamp;
  assign out_removed_count     = out_r.removed_count;

  a_we_only_report: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_RPT) && (op_r == OP_REPORT))
    else $error("entry memory written outside a report");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result appeared without passing the output state");

  a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_op == OP_TICK) |=> now_r == $past(now_r) + 32'd1)
    else $error("time counter did not advance on tick");

  a_time_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |=> $stable(now_r))
    else $error("time counter moved during a scan");

  a_valid_only_grows_on_report: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TICK) |=> $countones(valid_r) <= $countones($past(valid_r)))
    else $error("tick scan set a valid bit");

endmodule

// ===== dv/client_parent_table_with_aging_core_checker.sv =====
// Checker for the client-to-parent table: shadows the table, the tick counter and the timeout,
// predicts the result word of every accepted input word and compares it field by field.
// Depends on ctpt_pkg for table size, operation and status codes and the entry type.
module client_parent_table_with_aging_core_checker
  import ctpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [63:0] in_client_addr_high,
  input  logic [63:0] in_client_addr_low,
  input  logic [63:0] in_parent_addr_high,
  input  logic [63:0] in_parent_addr_low,
  input  logic [3:0]  in_read_slot,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_status,
  input  logic [3:0]  out_slot,
  input  logic        out_entry_valid,
  input  logic [63:0] out_entry_client_high,
  input  logic [63:0] out_entry_client_low,
  input  logic [63:0] out_entry_parent_high,
  input  logic [63:0] out_entry_parent_low,
  input  logic [31:0] out_entry_stamp,
  input  logic [4:0]  out_removed_count,
  input  logic        drain,
  output int          mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [TABLE_SLOTS-1:0] live;
  entry_t                 shadow [TABLE_SLOTS];
  logic [31:0]            now_ticks_q;
  logic [7:0]             timeout_q;
  res_t                   awaited [$];
  res_t                   want;
  bit                     drained = 1'b0;
  int                     result_idx = 0;

  initial mismatches = 0;

  task automatic report(input string msg);
    $display("[%0t] %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] exp);
    if (got !== exp)
      report($sformatf("result %0d %s: got %h, expected %h", result_idx, name, got, exp));
  endtask

  task automatic predict_word(input logic [1:0] op, input logic [63:0] ch, input logic [63:0] cl,
                              input logic [63:0] ph, input logic [63:0] pl,
                              input logic [3:0] rs, output res_t r);
    int          s;
    int          freed;
    bit          hit;
    logic [31:0] age;
    r = '0;
    hit = 1'b0;
    freed = 0;
    if (op == OP_REPORT) begin
      for (s = 0; s < TABLE_SLOTS && !hit; s++) begin
        if (live[s] && shadow[s].client_high == ch && shadow[s].client_low == cl) begin
          hit = 1'b1;
          shadow[s].parent_high = ph;
          shadow[s].parent_low = pl;
          shadow[s].stamp = now_ticks_q;
          r.status = ST_UPDATED;
          r.slot = s[3:0];
        end
      end
      for (s = 0; s < TABLE_SLOTS && !hit; s++) begin
        if (!live[s]) begin
          hit = 1'b1;
          live[s] = 1'b1;
          shadow[s] = '{client_high: ch, client_low: cl, parent_high: ph, parent_low: pl,
                        stamp: now_ticks_q};
          r.status = ST_INSERTED;
          r.slot = s[3:0];
        end
      end
      if (!hit)
        r.status = ST_DROPPED;
    end else if (op == OP_TICK) begin
      now_ticks_q = now_ticks_q + 32'd1;
      for (s = 0; s < TABLE_SLOTS; s++) begin
        age = now_ticks_q - shadow[s].stamp;
        if (live[s] && age >= {24'd0, timeout_q}) begin
          live[s] = 1'b0;
          freed++;
        end
      end
      r.status = ST_TICKED;
      r.removed_count = freed[4:0];
    end else begin
      r.status = ST_READ;
      r.slot = rs;
      if (live[rs]) begin
        r.entry_valid = 1'b1;
        r.entry = shadow[rs];
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      live = '0;
      now_ticks_q = '0;
      timeout_q = DEFAULT_TIMEOUT;
      awaited.delete();
    end else begin
      if (cfg_wr_en)
        timeout_q = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          report($sformatf("result %0d arrived with nothing awaited, status %0d",
                           result_idx, out_status));
        end else begin
          want = awaited.pop_front();
          compare_field("status", 64'(out_status), 64'(want.status));
          compare_field("slot", 64'(out_slot), 64'(want.slot));
          compare_field("entry_valid", 64'(out_entry_valid), 64'(want.entry_valid));
          compare_field("entry_client_high", out_entry_client_high, want.entry.client_high);
          compare_field("entry_client_low", out_entry_client_low, want.entry.client_low);
          compare_field("entry_parent_high", out_entry_parent_high, want.entry.parent_high);
          compare_field("entry_parent_low", out_entry_parent_low, want.entry.parent_low);
          compare_field("entry_stamp", 64'(out_entry_stamp), 64'(want.entry.stamp));
          compare_field("removed_count", 64'(out_removed_count), 64'(want.removed_count));
        end
        result_idx++;
      end
      if (in_valid && !in_stall) begin
        predict_word(in_op, in_client_addr_high, in_client_addr_low, in_parent_addr_high,
                     in_parent_addr_low, in_read_slot, want);
        awaited.push_back(want);
      end
      if (drain && !drained) begin
        drained = 1'b1;
        if (awaited.size() != 0)
          report($sformatf("%0d results never arrived", awaited.size()));
      end
    end
  end

endmodule

// ===== dv/client_parent_table_with_aging_core_tb.sv =====
// Top of the client-to-parent table testbench: clock, reset, timeout writes, report, tick
// and read words with random idling on both channels, and the verdict.
// Depends on ctpt_pkg, the table core and client_parent_table_with_aging_core_checker.
module client_parent_table_with_aging_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ctpt_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int POOL_SIZE = 20;
  localparam int PHASE_WORDS = 230;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_op = '0;
  logic [63:0] in_client_addr_high = '0;
  logic [63:0] in_client_addr_low = '0;
  logic [63:0] in_parent_addr_high = '0;
  logic [63:0] in_parent_addr_low = '0;
  logic [3:0]  in_read_slot = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [3:0]  out_slot;
  logic        out_entry_valid;
  logic [63:0] out_entry_client_high;
  logic [63:0] out_entry_client_low;
  logic [63:0] out_entry_parent_high;
  logic [63:0] out_entry_parent_low;
  logic [31:0] out_entry_stamp;
  logic [4:0]  out_removed_count;
  logic        drain = 1'b0;
  int          mismatches;

  logic                   idle_on = 1'b0;
  int                     stall_run = 0;
  int                     words_sent = 0;
  int                     words_back = 0;
  logic [TABLE_SLOTS-1:0] written = '0;
  logic [127:0]           client_pool [POOL_SIZE];
  logic [7:0]             cur_timeout = DEFAULT_TIMEOUT;

  client_parent_table_with_aging_core i_dut (.*);

  client_parent_table_with_aging_core_checker i_checker (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || !idle_on) begin
      stall_run <= 0;
      out_stall <= 1'b0;
    end else if (stall_run != 0) begin
      stall_run <= stall_run - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_run <= $urandom_range(0, 11);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      words_back <= words_back + 1;
      if (out_status == ST_INSERTED)
        written[out_slot] <= 1'b1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [127:0] client,
                           input logic [127:0] parent, input logic [3:0] rs);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    {in_client_addr_high, in_client_addr_low} <= client;
    {in_parent_addr_high, in_parent_addr_low} <= parent;
    in_read_slot <= rs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (words_back != words_sent) @(posedge clk);
    repeat (TABLE_SLOTS + 4) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [7:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    cur_timeout = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Clients sharing one half with a neighbour catch half-width matches.
  task automatic build_pool();
    int i;
    for (i = 0; i < POOL_SIZE; i++) begin
      client_pool[i] = {rand64(), rand64()};
      if (i > 0 && $urandom_range(0, 3) == 0)
        client_pool[i][127:64] = client_pool[i-1][127:64];
      else if (i > 0 && $urandom_range(0, 3) == 0)
        client_pool[i][63:0] = client_pool[i-1][63:0];
    end
  endtask

  task automatic send_random_word();
    int           pick;
    logic [1:0]   op;
    logic [127:0] client;
    logic [3:0]   rs;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 9) < 7)
      client = client_pool[$urandom_range(0, POOL_SIZE - 1)];
    else
      client = {rand64(), rand64()};
    rs = 4'($urandom_range(0, 15));
    if (pick < 55 || written == '0) begin
      op = OP_REPORT;
    end else if (pick < 75) begin
      op = OP_TICK;
    end else begin
      op = ($urandom_range(0, 3) == 0) ? OP_SPARE : OP_READ;
      while (!written[rs]) rs = 4'($urandom_range(0, 15));
    end
    send_word(op, client, {rand64(), rand64()}, rs);
  endtask

  initial begin
    logic [7:0] phase_timeout [6];
    int         p;
    int         n;
    phase_timeout[0] = 8'd255;
    phase_timeout[1] = 8'd1;
    phase_timeout[2] = 8'd0;
    phase_timeout[3] = 8'($urandom_range(2, 40));
    phase_timeout[4] = DEFAULT_TIMEOUT;
    phase_timeout[5] = 8'($urandom_range(4, 60));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(OP_REPORT, '0, '1, 4'h0);
    send_word(OP_REPORT, '1, '0, 4'hF);
    send_word(OP_REPORT, '0, {2{64'h5555_5555_5555_5555}}, 4'h0);
    send_word(OP_REPORT, {64'h0, 64'hFFFF_FFFF_FFFF_FFFF}, {64'hAAAA_AAAA_AAAA_AAAA, 64'h0},
              4'h0);
    wait_idle();
    send_word(OP_READ, '1, '1, 4'h0);
    send_word(OP_SPARE, '0, '0, 4'h1);
    send_word(OP_READ, '0, '0, 4'h2);
    send_word(OP_TICK, '0, '0, 4'h0);
    send_word(OP_TICK, '0, '0, 4'h0);
    send_word(OP_REPORT, '1, {2{64'h0123_4567_89AB_CDEF}}, 4'h0);
    send_word(OP_TICK, '0, '0, 4'h0);
    send_word(OP_READ, '0, '0, 4'h0);
    send_word(OP_READ, '0, '0, 4'h1);
    send_word(OP_REPORT, '0, '1, 4'h0);
    send_word(OP_READ, '0, '0, 4'h0);
    wait_idle();

    idle_on = 1'b1;
    for (p = 0; p < 6; p++) begin
      if (p == 5)
        idle_on = 1'b0;
      write_timeout(phase_timeout[p]);
      build_pool();
      for (n = 0; n < PHASE_WORDS; n++) send_random_word();
      // age everything out
      for (n = 0; n <= cur_timeout; n++) send_word(OP_TICK, '0, '0, 4'h0);
      wait_idle();
    end

    drain <= 1'b1;
    repeat (2) @(posedge clk);
    if (mismatches == 0)
      $display("[client_parent_table_with_aging_core] OK");
    else
      $display("[client_parent_table_with_aging_core] ERROR");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[client_parent_table_with_aging_core] ERROR");
    $finish;
  end

endmodule
